// ===== src/fdm_pkg.sv =====
// Shared types and constants for the floppy drive mechanics block.
// No dependencies; every other file imports this package.
package fdm_pkg;

    localparam int NUM_CYLINDERS = 80;
    localparam int CYL_W         = 7;
    localparam int ID_W          = 32;
    localparam int ID_CNT_W      = 5;
    localparam logic [CYL_W-1:0] CYL_MAX = CYL_W'(NUM_CYLINDERS - 1);
    localparam logic [ID_W-1:0]  ID_PATTERN_RST = 32'hFFFF_FFFF;

    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EJECT  = 2'd2;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             media_valid;
        logic             selected;
        logic             motor_cmd;
        logic             side_cmd;
        logic             step_cmd;
        logic             step_out;
    } fdm_item_t;

    typedef struct packed {
        logic             spindle_on;
        logic             side;
        logic [CYL_W-1:0] cylinder;
        logic             id_bit;
        logic             wpro_n;
        logic             dskchg_n;
        logic             track0;
        logic             ready_res;
    } fdm_result_t;

endpackage

// ===== src/fdm_in_reg.sv =====
// Input register stage: holds one accepted word until the core takes it.
// Depends on fdm_pkg.
module fdm_in_reg
    import fdm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  fdm_item_t in_item,
    output logic      item_valid,
    input  logic      item_take,
    output fdm_item_t item
);

    logic      valid_reg;
    fdm_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/fdm_core.sv =====
// Drive state registers and their single-pass update for one word.
// Depends on fdm_pkg.
module fdm_core
    import fdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  fdm_item_t         item,
    input  logic [ID_W-1:0]   id_pattern,
    output fdm_result_t       result
);

    logic                motor_reg,   motor_next;
    logic [CYL_W-1:0]    cyl_reg,     cyl_next;
    logic                side_reg,    side_next;
    logic                ready_reg,   ready_next;
    logic                track0_reg,  track0_next;
    logic                media_reg,   media_next;
    logic                change_reg,  change_next;
    logic                wprot_reg,   wprot_next;
    logic                armed_reg,   armed_next;
    logic [ID_CNT_W-1:0] id_cnt_reg,  id_cnt_next;
    logic [CYL_W-1:0]    cyl_stepped;

    always_comb
    begin
        if (item.step_out)
        begin
            cyl_stepped = (cyl_reg != '0) ? cyl_reg - CYL_W'(1) : cyl_reg;
        end
        else
        begin
            cyl_stepped = (cyl_reg < CYL_MAX) ? cyl_reg + CYL_W'(1) : cyl_reg;
        end
    end

    always_comb
    begin
        motor_next  = motor_reg;
        cyl_next    = cyl_reg;
        side_next   = side_reg;
        ready_next  = ready_reg;
        track0_next = track0_reg;
        media_next  = media_reg;
        change_next = change_reg;
        wprot_next  = wprot_reg;
        armed_next  = armed_reg;
        id_cnt_next = id_cnt_reg;
        unique case (item.action)
            ACT_SAMPLE:
            begin
                if (!item.selected)
                begin
                    if (!motor_reg)
                    begin
                        id_cnt_next = id_cnt_reg + ID_CNT_W'(1);
                    end
                end
                else
                begin
                    if (item.motor_cmd)
                    begin
                        if (!motor_reg)
                        begin
                            motor_next  = 1'b1;
                            ready_next  = media_reg;
                            id_cnt_next = '0;
                        end
                    end
                    else if (motor_reg)
                    begin
                        motor_next = 1'b0;
                        ready_next = 1'b0;
                    end
                    side_next = item.side_cmd;
                    if (item.step_cmd && armed_reg)
                    begin
                        armed_next  = 1'b0;
                        cyl_next    = cyl_stepped;
                        change_next = !media_reg;
                    end
                    if (!item.step_cmd)
                    begin
                        armed_next = 1'b1;
                    end
                    track0_next = (cyl_next == '0);
                end
            end
            ACT_INSERT:
            begin
                media_next  = item.media_valid;
                change_next = 1'b1;
                wprot_next  = 1'b1;
            end
            ACT_EJECT:
            begin
                media_next  = 1'b0;
                change_next = 1'b1;
                wprot_next  = 1'b0;
                ready_next  = 1'b0;
                motor_next  = 1'b0;
            end
            default:
            begin
                // unused action code: keep everything
            end
        endcase
    end

    always_comb
    begin
        result.ready_res  = ready_next;
        result.track0     = track0_next;
        result.dskchg_n   = !change_next;
        result.wpro_n     = media_next ? !wprot_next : 1'b1;
        result.id_bit     = id_pattern[~id_cnt_next];
        result.cylinder   = cyl_next;
        result.side       = side_next;
        result.spindle_on = motor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_reg  <= 1'b0;
            cyl_reg    <= '0;
            side_reg   <= 1'b0;
            ready_reg  <= 1'b0;
            track0_reg <= 1'b1;
            media_reg  <= 1'b0;
            change_reg <= 1'b1;
            wprot_reg  <= 1'b1;
            armed_reg  <= 1'b1;
            id_cnt_reg <= '0;
        end
        else if (advance)
        begin
            motor_reg  <= motor_next;
            cyl_reg    <= cyl_next;
            side_reg   <= side_next;
            ready_reg  <= ready_next;
            track0_reg <= track0_next;
            media_reg  <= media_next;
            change_reg <= change_next;
            wprot_reg  <= wprot_next;
            armed_reg  <= armed_next;
            id_cnt_reg <= id_cnt_next;
        end
    end

endmodule

// ===== src/fdm_out_reg.sv =====
// Result register: holds a finished word until the downstream side takes it.
// Depends on fdm_pkg.
module fdm_out_reg
    import fdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_valid,
    output logic        load_ready,
    input  fdm_result_t load_result,
    output logic        out_valid,
    input  logic        out_ready,
    output fdm_result_t out_result
);

    logic        valid_reg;
    fdm_result_t result_reg;

    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            result_reg <= load_result;
        end
    end

endmodule

// ===== src/floppy_drive_mechanics.sv =====
// Floppy drive mechanics: an accepted word waits in the input register, then moves to the
// result register, where the result word is offered; the drive state updates on that move.
// Throughput one word per cycle while the result side takes words; both registers stall with it.
// Reset (rst_n low, asynchronous): both stages empty, drive state at power-on
// values (motor off, head at cylinder 0, change latched), ID word all ones.
// Depends on fdm_pkg, fdm_in_reg, fdm_core, fdm_out_reg.
module floppy_drive_mechanics
    import fdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] media_valid, [1] selected, [2] motor_cmd, [3] side_cmd,
    // [4] step_cmd, [5] step_out, [7:6] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]      s_tuser,
    // Result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] ready_res, [1] track0, [2] dskchg_n, [3] wpro_n, [4] id_bit,
    // [11:5] cylinder, [12] side, [13] spindle_on, [15:14] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // ID word register write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [ID_W-1:0]       cfg_data
);

    fdm_item_t        in_item;
    fdm_item_t        item;
    logic             item_valid;
    logic             advance;
    logic             load_ready;
    fdm_result_t      core_result;
    fdm_result_t      out_result;
    logic [ID_W-1:0]  id_pattern_reg;

    // Unpack the incoming word into its fields.
    always_comb
    begin
        in_item.action      = s_tuser;
        in_item.media_valid = s_tdata[0];
        in_item.selected    = s_tdata[1];
        in_item.motor_cmd   = s_tdata[2];
        in_item.side_cmd    = s_tdata[3];
        in_item.step_cmd    = s_tdata[4];
        in_item.step_out    = s_tdata[5];
    end

    // The user must write the ID word only while the block is idle; the block does not enforce it. Accept it at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_pattern_reg <= ID_PATTERN_RST;
        end
        else if (cfg_valid)
        begin
            id_pattern_reg <= cfg_data;
        end
    end

    fdm_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (load_ready),
        .item       (item)
    );

    // Advance the drive state exactly when the held word moves into the result register.
    assign advance = item_valid && load_ready;

    fdm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .id_pattern (id_pattern_reg),
        .result     (core_result)
    );

    fdm_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (item_valid),
        .load_ready  (load_ready),
        .load_result (core_result),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    // Pack the result fields, lowest bit first, zero fill at the top.
    assign m_tdata = {2'b00, out_result};

endmodule

// ===== src/fdm_checker.sv =====
// Port-level checks for floppy_drive_mechanics, attached by bind.
// Depends on fdm_pkg and the top level's port list.
module fdm_checker
    import fdm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // Track0 always agrees with the reported cylinder.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1] == (m_tdata[11:5] == '0)))
        else $error("track0 disagrees with cylinder");

    // Ready can only be latched while the motor runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[13])
        else $error("ready without motor");

    // The head never passes the top cylinder.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:5] <= CYL_MAX))
        else $error("cylinder out of range");

endmodule

bind floppy_drive_mechanics fdm_checker u_fdm_checker (.*);

// ===== verif/floppy_drive_mechanics_tb.sv =====
// Self-checking testbench for floppy_drive_mechanics: directed table, then random
// seek, ID-shift and media sequences under varying backpressure.
// Depends on fdm_pkg and the floppy_drive_mechanics RTL.
module floppy_drive_mechanics_tb;
    import fdm_pkg::*;

    // Reserved action code; the drive must leave all state alone
    localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [0] media_valid, [1] selected, [2] motor_cmd, [3] side_cmd,
    // [4] step_cmd, [5] step_out, [7:6] zero
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // [1:0] action
    logic [ACT_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] ready_res, [1] track0, [2] dskchg_n, [3] wpro_n, [4] id_bit,
    // [11:5] cylinder, [12] side, [13] spindle_on, [15:14] zero
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [ID_W-1:0]       cfg_data = '0;

    floppy_drive_mechanics u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drive mechanics as the testbench believes them to be
    logic [ID_W-1:0]     mech_id_word = ID_PATTERN_RST;
    logic                mech_motor = 1'b0;
    logic [CYL_W-1:0]    mech_cyl = '0;
    logic                mech_side = 1'b0;
    logic                mech_ready = 1'b0;
    logic                mech_track0 = 1'b1;
    logic                mech_media = 1'b0;
    logic                mech_change = 1'b1;
    logic                mech_wprot = 1'b1;
    logic                mech_step_armed = 1'b1;
    logic [ID_CNT_W-1:0] mech_id_cnt = '0;

    // Line levels still owed by the block, oldest first
    fdm_result_t pending_lines[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int cycles        = 0;
    int words_sent    = 0;
    int words_seen    = 0;
    int mismatches    = 0;
    int id_writes     = 0;
    int media_changes = 0;
    int head_moves    = 0;
    int cyl_peak      = 0;

    typedef struct {
        fdm_item_t   word;
        bit          fixed;
        fdm_result_t lines;
    } stim_row_t;

    stim_row_t directed_rows[$];

    // Update the mechanics for one accepted word and return the line levels after it
    function automatic fdm_result_t advance_mechanics(input fdm_item_t w);
        fdm_result_t r;
        case (w.action)
            ACT_SAMPLE:
            begin
                if (!w.selected)
                begin
                    // Deselected: only the ID shift counter moves, and only with motor off
                    if (!mech_motor)
                        mech_id_cnt = mech_id_cnt + 1'b1;
                end
                else
                begin
                    if (w.motor_cmd)
                    begin
                        if (!mech_motor)
                        begin
                            mech_motor  = 1'b1;
                            mech_ready  = mech_media;
                            mech_id_cnt = '0;
                        end
                    end
                    else if (mech_motor)
                    begin
                        mech_motor = 1'b0;
                        mech_ready = 1'b0;
                    end
                    mech_side = w.side_cmd;
                    if (w.step_cmd && mech_step_armed)
                    begin
                        mech_step_armed = 1'b0;
                        head_moves++;
                        if (w.step_out)
                        begin
                            if (mech_cyl != 0)
                                mech_cyl = mech_cyl - 1'b1;
                        end
                        else if (mech_cyl < CYL_MAX)
                            mech_cyl = mech_cyl + 1'b1;
                        mech_change = !mech_media;
                    end
                    if (!w.step_cmd)
                        mech_step_armed = 1'b1;
                    mech_track0 = (mech_cyl == 0);
                    if (int'(mech_cyl) > cyl_peak)
                        cyl_peak = int'(mech_cyl);
                end
            end
            ACT_INSERT:
            begin
                mech_media  = w.media_valid;
                mech_change = 1'b1;
                mech_wprot  = 1'b1;
                media_changes++;
            end
            ACT_EJECT:
            begin
                mech_media  = 1'b0;
                mech_change = 1'b1;
                mech_wprot  = 1'b0;
                mech_ready  = 1'b0;
                mech_motor  = 1'b0;
                media_changes++;
            end
            default:
            begin
                // reserved code: hold everything
            end
        endcase
        r.ready_res  = mech_ready;
        r.track0     = mech_track0;
        r.dskchg_n   = !mech_change;
        r.wpro_n     = mech_media ? !mech_wprot : 1'b1;
        r.id_bit     = mech_id_word[5'd31 - mech_id_cnt];
        r.cylinder   = mech_cyl;
        r.side       = mech_side;
        r.spindle_on = mech_motor;
        return r;
    endfunction

    function automatic fdm_item_t ctl(input bit sel, input bit mot, input bit sid,
                                      input bit stp, input bit dir);
        fdm_item_t w;
        w.action      = ACT_SAMPLE;
        w.media_valid = $urandom_range(1);
        w.selected    = sel;
        w.motor_cmd   = mot;
        w.side_cmd    = sid;
        w.step_cmd    = stp;
        w.step_out    = dir;
        return w;
    endfunction

    function automatic fdm_item_t media_word(input logic [ACT_W-1:0] act, input bit mv);
        fdm_item_t w;
        w             = fdm_item_t'($urandom);
        w.action      = act;
        w.media_valid = mv;
        return w;
    endfunction

    function automatic fdm_result_t lines(input bit rdy, input bit t0, input bit chg_n,
                                          input bit wp_n, input bit idb,
                                          input int cyl, input bit sid, input bit mot);
        fdm_result_t r;
        r.ready_res  = rdy;
        r.track0     = t0;
        r.dskchg_n   = chg_n;
        r.wpro_n     = wp_n;
        r.id_bit     = idb;
        r.cylinder   = CYL_W'(cyl);
        r.side       = sid;
        r.spindle_on = mot;
        return r;
    endfunction

    function automatic string show_lines(input fdm_result_t r);
        return $sformatf("rdy=%b t0=%b chg_n=%b wp_n=%b id=%b cyl=%0d side=%b mot=%b",
                         r.ready_res, r.track0, r.dskchg_n, r.wpro_n, r.id_bit,
                         r.cylinder, r.side, r.spindle_on);
    endfunction

    function automatic void add_row(input fdm_item_t w, input bit fixed,
                                    input fdm_result_t r);
        stim_row_t row;
        row.word  = w;
        row.fixed = fixed;
        row.lines = r;
        directed_rows.push_back(row);
    endfunction

    // Offer one word, idling first at the sender's rate; push what it must produce
    task automatic send_word(input fdm_item_t w, input bit fixed, input fdm_result_t lit);
        fdm_result_t pred;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, w.step_out, w.step_cmd, w.side_cmd, w.motor_cmd,
                     w.selected, w.media_valid};
        s_tuser  <= w.action;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = advance_mechanics(w);
        pending_lines.push_back(fixed ? lit : pred);
        words_sent++;
    endtask

    task automatic send(input fdm_item_t w);
        send_word(w, 1'b0, '0);
    endtask

    // Drop valid and wait for the block to hand back every owed word
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_id_word(input logic [ID_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        mech_id_word = v;
        id_writes++;
    endtask

    // Usually spin up, then a run of step pulses in one direction, with the odd noise word
    task automatic seek_run;
        bit dir;
        bit sid;
        bit mot;
        int pulses;
        dir    = $urandom_range(1);
        sid    = $urandom_range(1);
        mot    = ($urandom_range(9) != 0);
        pulses = ($urandom_range(3) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 20);
        if ($urandom_range(3) == 0)
            send(media_word(ACT_INSERT, $urandom_range(7) != 0));
        send(ctl(1'b1, mot, sid, 1'b0, dir));
        for (int k = 0; k < pulses; k++)
        begin
            if ($urandom_range(15) == 0)
                sid = !sid;
            send(ctl(1'b1, mot, sid, 1'b1, dir));
            if ($urandom_range(7) == 0)
                send(ctl(1'b1, mot, sid, 1'b1, $urandom_range(1)));
            if ($urandom_range(31) == 0)
                send(fdm_item_t'($urandom));
            send(ctl(1'b1, mot, sid, 1'b0, dir));
        end
    endtask

    // Walk the ID shift counter, usually with the motor stopped so it advances
    task automatic id_walk;
        int n;
        n = $urandom_range(1, 40);
        if ($urandom_range(3) != 0)
            send(ctl(1'b1, 1'b0, $urandom_range(1), $urandom_range(1), $urandom_range(1)));
        for (int k = 0; k < n; k++)
            send(ctl(1'b0, $urandom_range(1), $urandom_range(1), $urandom_range(1),
                     $urandom_range(1)));
        if ($urandom_range(1) == 0)
            send(ctl(1'b1, 1'b1, $urandom_range(1), 1'b0, $urandom_range(1)));
    endtask

    task automatic random_phase(input int n_words, input bit with_hold);
        int start;
        int pick;
        bit held;
        start = words_sent;
        held  = 1'b0;
        while (words_sent - start < n_words)
        begin
            // hold the result side off for a long stretch while words keep coming
            if (with_hold && !held && words_sent - start > n_words / 2)
            begin
                hold_request = 80;
                held         = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55)
                seek_run();
            else if (pick < 75)
                id_walk();
            else if (pick < 85)
                send(media_word($urandom_range(1) ? ACT_INSERT : ACT_EJECT,
                                $urandom_range(1)));
            else
                send(fdm_item_t'($urandom));
        end
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Compare each returned word with the oldest owed line levels
    always @(posedge clk)
    begin : result_check
        fdm_result_t got;
        fdm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = fdm_result_t'(m_tdata[13:0]);
            words_seen++;
            if (pending_lines.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("t=%0t unexpected word: %s", $realtime, show_lines(got));
            end
            else
            begin
                want = pending_lines.pop_front();
                if (got.ready_res !== want.ready_res || got.track0 !== want.track0 ||
                    got.dskchg_n !== want.dskchg_n || got.wpro_n !== want.wpro_n ||
                    got.id_bit !== want.id_bit || got.cylinder !== want.cylinder ||
                    got.side !== want.side || got.spindle_on !== want.spindle_on ||
                    m_tdata[15:14] !== 2'b00)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("t=%0t word %0d mismatch (pad=%b)", $realtime,
                                 words_seen, m_tdata[15:14]);
                        $display("  expected %s", show_lines(want));
                        $display("  actual   %s", show_lines(got));
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words owed", cycles,
                     pending_lines.size());
            $display("** floppy_drive_mechanics: FAILED **");
            $finish;
        end
    end

    initial
    begin
        // After reset with the ID word all ones, the first rows read off at a glance
        add_row(ctl(0, 0, 0, 0, 0), 1, lines(0, 1, 0, 1, 1, 0, 0, 0));
        add_row('{action: ACT_RESERVED, media_valid: 1, selected: 1, motor_cmd: 1,
                  side_cmd: 1, step_cmd: 1, step_out: 1},
                1, lines(0, 1, 0, 1, 1, 0, 0, 0));
        // step out at cylinder zero, no media: head stays, change stays latched
        add_row(ctl(1, 0, 1, 1, 1), 1, lines(0, 1, 0, 1, 1, 0, 1, 0));
        add_row(media_word(ACT_INSERT, 1), 1, lines(0, 1, 0, 0, 1, 0, 1, 0));
        add_row(ctl(1, 1, 0, 0, 0), 1, lines(1, 1, 0, 0, 1, 0, 0, 1));
        add_row(ctl(1, 1, 0, 1, 0), 0, '0);
        add_row(ctl(1, 1, 0, 1, 0), 0, '0);
        add_row(ctl(1, 1, 1, 0, 0), 0, '0);
        add_row(ctl(1, 1, 1, 1, 0), 0, '0);
        add_row(ctl(1, 1, 1, 0, 1), 0, '0);
        add_row(ctl(1, 1, 1, 1, 1), 0, '0);
        add_row(ctl(0, 1, 0, 1, 0), 0, '0);
        add_row(ctl(1, 0, 0, 0, 0), 0, '0);
        add_row(ctl(0, 0, 1, 1, 1), 0, '0);
        add_row(ctl(1, 1, 0, 0, 0), 0, '0);
        add_row(media_word(ACT_EJECT, 1), 0, '0);
        add_row(ctl(1, 1, 0, 0, 0), 0, '0);
        add_row(ctl(1, 1, 0, 1, 0), 0, '0);
        add_row(media_word(ACT_INSERT, 0), 0, '0);
        add_row(ctl(1, 0, 0, 0, 1), 0, '0);
        add_row(media_word(ACT_INSERT, 1), 0, '0);
        add_row(ctl(1, 1, 0, 1, 1), 0, '0);
        add_row(ctl(1, 1, 0, 0, 1), 0, '0);
        add_row(ctl(1, 1, 0, 1, 1), 0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 9;
        sink_idle_pct = 57;
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].fixed,
                      directed_rows[i].lines);
        drain();

        // Phase one: sender mostly busy, receiver stalls often, ID word all zeros
        load_id_word('0);
        random_phase(140, 1'b0);
        drain();

        // Phase two: roles swapped, random ID word
        src_idle_pct  = 57;
        sink_idle_pct = 9;
        load_id_word($urandom);
        random_phase(140, 1'b0);
        drain();

        // Phase three: no idling, a mixed ID word, then all ones; long hold-off
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        load_id_word(32'hA5C3_0F69);
        random_phase(60, 1'b1);
        drain();
        load_id_word(32'hFFFF_FFFF);
        random_phase(60, 1'b0);
        drain();
        repeat (6) @(posedge clk);

        if (pending_lines.size() != 0)
        begin
            mismatches++;
            $display("%0d words never returned", pending_lines.size());
        end
        $display("Ran %0d words (%0d media changes, %0d head steps, peak cylinder %0d)",
                 words_sent, media_changes, head_moves, cyl_peak);
        $display("across %0d ID word settings; %0d mismatches", id_writes, mismatches);
        if (mismatches == 0)
            $display("** floppy_drive_mechanics: PASSED **");
        else
            $display("** floppy_drive_mechanics: FAILED **");
        $finish;
    end

endmodule
